// ===== design/scalar_mod_group_order_alu_assert.svh =====
// Assertion macros for the scalar mod-l arithmetic unit
`ifndef SCALAR_MOD_GROUP_ORDER_ALU_ASSERT_SVH
`define SCALAR_MOD_GROUP_ORDER_ALU_ASSERT_SVH
`ifndef SYNTH
// checked outside reset
`define SMGO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smgo assertion failed");
// checked at every edge, reset included
`define SMGO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("smgo assertion failed");
`else
`define SMGO_ASSERT(lbl, prop)
`define SMGO_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/smgo_pkg.sv =====
// Constants and types for the scalar mod-l arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package smgo_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_MULS = 3'd3,
    OP_RED  = 3'd4
  } op_t;

  localparam int LIMB_W = 64;
  localparam int LO_W   = 252;
  localparam int RES_W  = 253;

  // group order l = 2^252 + c
  localparam logic [252:0] ORDER_L =
    253'h1000000000000000_0000000000000000_14def9dea2f79cd6_5812631a5cf5d3ed;
  localparam logic [127:0] ORDER_C = 128'h14def9dea2f79cd6_5812631a5cf5d3ed;
  localparam logic [257:0] ORDER_L16 = {1'b0, ORDER_L, 4'b0};

  // fold widths and offsets (multiples of l that cover h*c)
  localparam int T1_W = 387;
  localparam int T2_W = 262;
  localparam int T3_W = 254;
  localparam logic [T1_W-1:0] FOLD1_M = {1'b0, ORDER_L, 133'b0};
  localparam logic [T2_W-1:0] FOLD2_M = {1'b0, ORDER_L, 8'b0};
  localparam logic [T3_W-1:0] FOLD3_M = {1'b0, ORDER_L};

endpackage
`default_nettype wire

// ===== design/smgo_cmul.sv =====
// Fold stage: t = lo + M - h * c, as four register stages
`timescale 1ns / 1ps
`default_nettype none
module smgo_cmul #(
  parameter int HW = 260,
  parameter int TW = smgo_pkg::T1_W,
  parameter logic [TW-1:0] M = smgo_pkg::FOLD1_M
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire logic [HW-1:0]             h,
  input  wire logic [smgo_pkg::LO_W-1:0] lo,
  output logic                           out_vld,
  output logic [TW-1:0]                  t
);
  localparam int NC   = (HW + 31) / 32;
  localparam int HX_W = 32 * NC;
  localparam int PW   = HX_W + 128;
  localparam int LW   = smgo_pkg::LO_W;

  logic [HX_W-1:0] hx;
  logic [63:0]     pp_r [NC][4];
  logic [159:0]    row_nxt [NC];
  logic [159:0]    row_r [NC];
  logic [PW-1:0]   prod_nxt;
  logic [PW-1:0]   prod_r;
  logic [TW-1:0]   t_r;
  logic [LW-1:0]   lo1_r, lo2_r, lo3_r;
  logic [3:0]      v_r;

  assign hx = HX_W'(h);

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < 4; j++) begin
        row_nxt[i] = row_nxt[i] + (160'(pp_r[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    prod_nxt = '0;
    for (int i = 0; i < NC; i++) begin
      prod_nxt = prod_nxt + (PW'(row_r[i]) << (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp_r[i][j] <= 64'(hx[32*i +: 32]) * 64'(smgo_pkg::ORDER_C[32*j +: 32]);
        end
      end
      lo1_r  <= lo;
      row_r  <= row_nxt;
      lo2_r  <= lo1_r;
      prod_r <= prod_nxt;
      lo3_r  <= lo2_r;
      // prod stays below M, so the difference never wraps
      t_r    <= TW'(lo3_r) + M - TW'(prod_r);
    end
  end

  assign out_vld = v_r[3];
  assign t       = t_r;
endmodule
`default_nettype wire

// ===== design/scalar_mod_group_order_alu.sv =====
// Scalar arithmetic modulo the ed25519 group order: top level
//
// One request carries an operation in in_tuser and operands a, b in in_tdata;
// one result (residue below l) leaves on the out_ stream for every request.
// Operations: add, subtract, multiply, multiply by the low 32 bits of b,
// reduce a (unused codes reduce a too). Operands may be any 256-bit value.
// On the way from acceptance to out_tvalid, three stages build the
// 512-bit value (32x32 partial products, row sums, final sum), three folds of
// the top bits by 2^252 = -c (four stages each), then one conditional
// subtraction of l into the output register.
// Throughput is one request per cycle. When the receiver stalls, the whole
// pipeline holds and in_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the unit holds no other state.
`timescale 1ns / 1ps
`default_nettype none
`include "scalar_mod_group_order_alu_assert.svh"
module scalar_mod_group_order_alu (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // a_limb0, a_limb1, a_limb2, a_limb3, b_limb0, b_limb1, b_limb2, b_limb3
  input  wire logic [511:0] in_tdata,
  // req_type
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // res_limb0, res_limb1, res_limb2, res_limb3 (61 bits), 3 zero bits
  output logic [255:0]      out_tdata
);
  logic             en;
  logic [255:0]     a, b, bsel;
  smgo_pkg::op_t    op;
  logic             is_mul;
  logic [257:0]     lin;

  logic [63:0]      pp_r [8][8];
  logic [287:0]     row_nxt [8];
  logic [287:0]     row_r [8];
  logic [511:0]     wsum;
  logic [511:0]     w_r;
  logic [257:0]     lin1_r, lin2_r;
  logic             mul1_r, mul2_r;
  logic [2:0]       v_r;

  logic             v1, v2, v3;
  logic [smgo_pkg::T1_W-1:0] t1;
  logic [smgo_pkg::T2_W-1:0] t2;
  logic [smgo_pkg::T3_W-1:0] t3;
  logic [smgo_pkg::T3_W-1:0] t3_sub;
  logic [smgo_pkg::RES_W-1:0] res_nxt;
  logic [smgo_pkg::RES_W-1:0] res_r;
  logic             out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign a  = in_tdata[255:0];
  assign b  = in_tdata[511:256];
  assign op = smgo_pkg::op_t'(in_tuser);

  always_comb begin
    is_mul = 1'b0;
    bsel   = b;
    unique case (op)
      smgo_pkg::OP_ADD: lin = {2'b0, a} + {2'b0, b};
      // a - b + 16l stays positive for any 256-bit b
      smgo_pkg::OP_SUB: lin = {2'b0, a} + smgo_pkg::ORDER_L16 - {2'b0, b};
      smgo_pkg::OP_MUL: begin
        lin    = {2'b0, a};
        is_mul = 1'b1;
      end
      smgo_pkg::OP_MULS: begin
        lin    = {2'b0, a};
        is_mul = 1'b1;
        bsel   = {224'b0, b[31:0]};
      end
      default: lin = {2'b0, a};
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < 8; j++) begin
        row_nxt[i] = row_nxt[i] + (288'(pp_r[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    wsum = '0;
    for (int i = 0; i < 8; i++) begin
      wsum = wsum + (512'(row_r[i]) << (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) begin
          pp_r[i][j] <= 64'(a[32*i +: 32]) * 64'(bsel[32*j +: 32]);
        end
      end
      lin1_r <= lin;
      mul1_r <= is_mul;
      row_r  <= row_nxt;
      lin2_r <= lin1_r;
      mul2_r <= mul1_r;
      w_r    <= mul2_r ? wsum : 512'(lin2_r);
    end
  end

  smgo_cmul #(
    .HW(260), .TW(smgo_pkg::T1_W), .M(smgo_pkg::FOLD1_M)
  ) u_fold1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v_r[2]),
    .h(w_r[511:252]), .lo(w_r[251:0]), .out_vld(v1), .t(t1)
  );

  smgo_cmul #(
    .HW(smgo_pkg::T1_W - 252), .TW(smgo_pkg::T2_W), .M(smgo_pkg::FOLD2_M)
  ) u_fold2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v1),
    .h(t1[smgo_pkg::T1_W-1:252]), .lo(t1[251:0]), .out_vld(v2), .t(t2)
  );

  smgo_cmul #(
    .HW(smgo_pkg::T2_W - 252), .TW(smgo_pkg::T3_W), .M(smgo_pkg::FOLD3_M)
  ) u_fold3 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v2),
    .h(t2[smgo_pkg::T2_W-1:252]), .lo(t2[251:0]), .out_vld(v3), .t(t3)
  );

  // t3 < 2l, one subtraction finishes the reduction
  assign t3_sub  = t3 - smgo_pkg::T3_W'(smgo_pkg::ORDER_L);
  assign res_nxt = (t3 >= smgo_pkg::T3_W'(smgo_pkg::ORDER_L)) ?
                   t3_sub[smgo_pkg::RES_W-1:0] : t3[smgo_pkg::RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, res_r};

  `SMGO_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_tvalid)
  `SMGO_ASSERT(a_ready_rule, in_tready == (!out_tvalid || out_tready))
  `SMGO_ASSERT(a_res_reduced, out_tvalid |-> (out_tdata[252:0] < smgo_pkg::ORDER_L))
  `SMGO_ASSERT(a_stall_hold, (out_tvalid && !out_tready) |=> $stable(v_r))
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the mod-l scalar arithmetic unit
`timescale 1ns / 1ps
module tb_top;

  localparam logic [255:0] GRP_L = {3'b0, smgo_pkg::ORDER_L};

  typedef struct {
    logic [2:0]   op;
    logic [255:0] a;
    logic [255:0] b;
    logic         chk;
    logic [255:0] res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [511:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [255:0] out_tdata;

  logic [255:0] residue_q[$];
  int fail_cnt = 0;
  int req_cnt = 0;
  int res_cnt = 0;
  int op_seen[8];
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  stim_row_t dir_rows[$];

  scalar_mod_group_order_alu DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [255:0] mod_l(logic [511:0] w);
    return 256'(w % {259'b0, GRP_L});
  endfunction

  function automatic logic [255:0] scalar_result(logic [2:0] op, logic [255:0] a,
                                                 logic [255:0] b);
    logic [255:0] ra, rb;
    case (op)
      smgo_pkg::OP_ADD: return mod_l({256'b0, a} + {256'b0, b});
      smgo_pkg::OP_SUB: begin
        ra = mod_l({256'b0, a});
        rb = mod_l({256'b0, b});
        return (ra >= rb) ? ra - rb : ra + GRP_L - rb;
      end
      smgo_pkg::OP_MUL: return mod_l({256'b0, a} * {256'b0, b});
      smgo_pkg::OP_MULS: return mod_l({256'b0, a} * {480'b0, b[31:0]});
      default: return mod_l({256'b0, a});
    endcase
  endfunction

  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    case ($urandom_range(0, 7))
      0: v = GRP_L - 256'($urandom_range(0, 3));
      1: v = GRP_L + 256'($urandom_range(0, 3));
      2: v = '1 - 256'($urandom_range(0, 3));
      3: v = 256'($urandom_range(0, 3));
      4: v = v % GRP_L;
      default: ;
    endcase
    return v;
  endfunction

  // sender: bursts with random gaps; one NBA per signal per edge
  task automatic send_req(logic [2:0] op, logic [255:0] a, logic [255:0] b,
                          logic chk, logic [255:0] res);
    logic [255:0] exp_r;
    exp_r = scalar_result(op, a, b);
    if (chk && exp_r != res) begin
      $error("directed row: predictor res expected %h actual %h", res, exp_r);
      fail_cnt++;
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    residue_q.push_back(chk ? res : exp_r);
    req_cnt++;
    op_seen[op]++;
  endtask

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 6);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic void add_row(logic [2:0] op, logic [255:0] a, logic [255:0] b,
                                  logic chk, logic [255:0] res);
    stim_row_t r;
    r.op = op; r.a = a; r.b = b; r.chk = chk; r.res = res;
    dir_rows.push_back(r);
  endfunction

  initial begin
    logic [255:0] ones;
    ones = '1;
    add_row(smgo_pkg::OP_ADD, 0, 0, 1, 0);
    add_row(smgo_pkg::OP_ADD, GRP_L - 1, 1, 1, 0);
    add_row(smgo_pkg::OP_ADD, ones, ones, 0, 0);
    add_row(smgo_pkg::OP_SUB, 0, 0, 1, 0);
    add_row(smgo_pkg::OP_SUB, 0, 1, 1, GRP_L - 1);
    add_row(smgo_pkg::OP_SUB, GRP_L, 0, 1, 0);
    add_row(smgo_pkg::OP_SUB, ones, ones, 1, 0);
    add_row(smgo_pkg::OP_SUB, 0, ones, 0, 0);
    add_row(smgo_pkg::OP_MUL, ones, ones, 0, 0);
    add_row(smgo_pkg::OP_MUL, GRP_L - 1, GRP_L - 1, 1, 1);
    add_row(smgo_pkg::OP_MUL, ones, 0, 1, 0);
    add_row(smgo_pkg::OP_MULS, ones, ones, 0, 0);
    add_row(smgo_pkg::OP_MULS, 5, {224'b0, 32'h0000_0002} | {ones[255:32], 32'h2},
            1, 10);
    add_row(smgo_pkg::OP_MULS, ones, {ones[255:32], 32'h0}, 1, 0);
    add_row(smgo_pkg::OP_RED, GRP_L, ones, 1, 0);
    add_row(smgo_pkg::OP_RED, ones, 0, 0, 0);
    add_row(smgo_pkg::OP_RED, GRP_L - 1, 0, 1, GRP_L - 1);
    add_row(3'd5, GRP_L + 7, ones, 1, 7);
    add_row(3'd6, 0, 0, 1, 0);
    add_row(3'd7, ones, ones, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].chk,
               dir_rows[i].res);
      idle_gap();
    end
    for (int i = 0; i < 900; i++) begin
      if (i == 300) hold_off = 1'b1;
      send_req(3'($urandom_range(0, 7)), rand_operand(), rand_operand(), 0, 0);
      if (i < 300 || i > 500) idle_gap();
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: own stall pattern, plus one long hold-off while the sender pushes
  initial begin
    int mode;
    mode = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    logic [255:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      res_cnt++;
      if (residue_q.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        fail_cnt++;
      end else begin
        want = residue_q.pop_front();
        for (int k = 0; k < 4; k++)
          if (out_tdata[k*64 +: 64] != want[k*64 +: 64]) begin
            $error("res_limb%0d expected %h actual %h", k, want[k*64 +: 64],
                   out_tdata[k*64 +: 64]);
            fail_cnt++;
          end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (residue_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d requests, %0d results; ops add %0d sub %0d mul %0d muls %0d red %0d",
             req_cnt, res_cnt, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
             op_seen[4] + op_seen[5] + op_seen[6] + op_seen[7]);
    $display("operands at, around and far above l; long output stall included");
    if (fail_cnt == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    #200000;
    $display("tb_top failed");
    $finish;
  end
endmodule
